// ===== sv/assert_macros.svh =====
// Assertion macros shared by the console engine modules.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every clock edge outside reset
`define TCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check prop on every clock edge, reset included
`define TCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/tce_pkg.sv =====
// Shared codes, constants and controller/datapath command types
// for the text console engine. Depends on nothing.
package tce_pkg;

    localparam logic [2:0] FN_PUT_CHAR   = 3'd0;
    localparam logic [2:0] FN_CLEAR      = 3'd1;
    localparam logic [2:0] FN_SET_CURSOR = 3'd2;
    localparam logic [2:0] FN_PUT_AT     = 3'd3;
    localparam logic [2:0] FN_READ_CELL  = 3'd4;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    localparam int TAB_STEP = 8;

    localparam logic [7:0]  RESET_COLOR = 8'h0F;
    localparam logic [15:0] RESET_CELL  = {RESET_COLOR, BLANK_CHAR};

    typedef struct packed {
        logic load_item;
        logic make_plan;
        logic commit;
        logic scr_rd;
        logic scr_wr;
        logic fill_wr;
        logic init_mode;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic do_clear;
        logic do_scroll;
        logic copy_last;
        logic fill_last;
    } t_dp_stat;

endpackage

// ===== sv/tce_if.sv =====
// Valid/ready channel interfaces for console items and results.
// Depends on nothing.
interface tce_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] char_code;
    logic [7:0] cell_attr;
    logic [6:0] x_pos;
    logic [5:0] y_pos;

    modport source (output valid, func, char_code, cell_attr, x_pos, y_pos, input ready);
    modport sink   (input valid, func, char_code, cell_attr, x_pos, y_pos, output ready);
endinterface

interface tce_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_linear;

    modport source (output valid, cell_value, cursor_row, cursor_col, cursor_linear,
                    input ready);
    modport sink   (input valid, cell_value, cursor_row, cursor_col, cursor_linear,
                    output ready);
endinterface

// ===== sv/tce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tce_datapath.sv =====
// Datapath of the console engine: item latch, cursor, color, cell RAM,
// sweep address and result register. Depends on tce_pkg and tce_ram.
`include "assert_macros.svh"

module tce_datapath import tce_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_cell_attr,
    input  logic [6:0]  i_x_pos,
    input  logic [5:0]  i_y_pos,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic [15:0] o_cell_value,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [10:0] o_cursor_linear
);

    localparam int CELLS     = ROWS * COLS;
    localparam int AW        = $clog2(CELLS);
    localparam int RW        = $clog2(ROWS);
    localparam int RW1       = RW + 1;
    localparam int COPY_LAST = (ROWS - 1) * COLS - 1;

    logic [2:0]    r_func;
    logic [7:0]    r_char;
    logic [7:0]    r_attr;
    logic [6:0]    r_x;
    logic [5:0]    r_y;
    logic [7:0]    r_color;
    logic [RW-1:0] r_row;
    logic [6:0]    r_col;
    logic [AW-1:0] r_addr;

    logic          r_p_write, r_p_read, r_p_clear, r_p_scroll;
    logic [AW-1:0] r_p_waddr, r_p_raddr;
    logic [15:0]   r_p_wdata;
    logic [RW-1:0] r_p_row;
    logic [6:0]    r_p_col;

    logic          n_p_write, n_p_read, n_p_clear, n_p_scroll;
    logic [AW-1:0] n_p_waddr;
    logic [15:0]   n_p_wdata;
    logic [RW-1:0] n_p_row;
    logic [6:0]    n_p_col;

    logic [15:0]   r_cell_value;
    logic [4:0]    r_cursor_row;
    logic [6:0]    r_cursor_col;
    logic [10:0]   r_cursor_linear;

    logic          in_range;
    logic [AW-1:0] cur_addr, xy_addr;
    logic [7:0]    col_inc, tab_col;
    logic [RW1-1:0] row_inc;
    logic          nl_scroll;
    logic [RW-1:0] nl_row;
    logic [13:0]   lin_full;
    logic [5:0]    row_ext;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata, fill_cell;

    assign in_range  = (8'(r_x) < 8'(COLS)) && (7'(r_y) < 7'(ROWS));
    assign cur_addr  = AW'(AW'(r_row) * AW'(COLS) + AW'(r_col));
    assign xy_addr   = AW'(AW'(r_y) * AW'(COLS) + AW'(r_x));
    assign col_inc   = {1'b0, r_col} + 8'd1;
    assign tab_col   = ({1'b0, r_col} + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
    assign row_inc   = {1'b0, r_row} + RW1'(1);
    assign nl_scroll = row_inc >= RW1'(ROWS);
    assign nl_row    = nl_scroll ? RW'(ROWS - 1) : row_inc[RW-1:0];

    always_comb begin
        n_p_write  = 1'b0;
        n_p_waddr  = cur_addr;
        n_p_wdata  = {r_color, r_char};
        n_p_read   = 1'b0;
        n_p_clear  = 1'b0;
        n_p_scroll = 1'b0;
        n_p_row    = r_row;
        n_p_col    = r_col;
        case (r_func)
            FN_PUT_CHAR: begin
                if (r_char == CH_NEWLINE) begin
                    n_p_col    = 7'd0;
                    n_p_row    = nl_row;
                    n_p_scroll = nl_scroll;
                end else if (r_char == CH_RETURN) begin
                    n_p_col = 7'd0;
                end else if (r_char == CH_TAB) begin
                    if (tab_col >= 8'(COLS)) begin
                        n_p_col    = 7'd0;
                        n_p_row    = nl_row;
                        n_p_scroll = nl_scroll;
                    end else begin
                        n_p_col = tab_col[6:0];
                    end
                end else if (r_char == CH_BACKSPACE) begin
                    if (r_col != 7'd0) begin
                        n_p_write = 1'b1;
                        n_p_waddr = cur_addr - AW'(1);
                        n_p_wdata = {r_color, BLANK_CHAR};
                        n_p_col   = r_col - 7'd1;
                    end
                end else begin
                    n_p_write = 1'b1;
                    if (col_inc >= 8'(COLS)) begin
                        n_p_col    = 7'd0;
                        n_p_row    = nl_row;
                        n_p_scroll = nl_scroll;
                    end else begin
                        n_p_col = col_inc[6:0];
                    end
                end
            end
            FN_CLEAR: begin
                n_p_clear = 1'b1;
                n_p_row   = '0;
                n_p_col   = 7'd0;
            end
            FN_SET_CURSOR: begin
                if (in_range) begin
                    n_p_row = RW'(r_y);
                    n_p_col = r_x;
                end
            end
            FN_PUT_AT: begin
                if (in_range) begin
                    n_p_write = 1'b1;
                    n_p_waddr = xy_addr;
                    n_p_wdata = {r_attr, r_char};
                end
            end
            FN_READ_CELL: begin
                n_p_read = in_range;
            end
            default: begin
                n_p_write = 1'b0;
            end
        endcase
    end

    assign fill_cell = i_cmd.init_mode ? RESET_CELL : {r_color, BLANK_CHAR};
    assign ram_we    = (i_cmd.commit && r_p_write) || i_cmd.scr_wr || i_cmd.fill_wr;
    assign ram_waddr = i_cmd.commit ? r_p_waddr : r_addr;
    assign ram_wdata = i_cmd.commit ? r_p_wdata : (i_cmd.scr_wr ? ram_rdata : fill_cell);
    assign ram_re    = (i_cmd.commit && r_p_read) || i_cmd.scr_rd;
    assign ram_raddr = i_cmd.scr_rd ? AW'(r_addr + AW'(COLS)) : r_p_raddr;

    tce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign row_ext  = 6'(r_row);
    assign lin_full = 14'(r_row) * 14'(COLS) + 14'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
            r_row   <= '0;
            r_col   <= 7'd0;
            r_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_row  <= r_p_row;
                r_col  <= r_p_col;
                r_addr <= '0;
            end else if (i_cmd.scr_wr || i_cmd.fill_wr) begin
                r_addr <= (i_cmd.fill_wr && o_stat.fill_last) ? '0 : r_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_char <= i_char_code;
            r_attr <= i_cell_attr;
            r_x    <= i_x_pos;
            r_y    <= i_y_pos;
        end
        if (i_cmd.make_plan) begin
            r_p_write  <= n_p_write;
            r_p_waddr  <= n_p_waddr;
            r_p_wdata  <= n_p_wdata;
            r_p_read   <= n_p_read;
            r_p_raddr  <= xy_addr;
            r_p_clear  <= n_p_clear;
            r_p_scroll <= n_p_scroll;
            r_p_row    <= n_p_row;
            r_p_col    <= n_p_col;
        end
        if (i_cmd.load_out) begin
            r_cell_value    <= r_p_read ? ram_rdata : 16'd0;
            r_cursor_row    <= row_ext[4:0];
            r_cursor_col    <= r_col;
            r_cursor_linear <= lin_full[10:0];
        end
    end

    assign o_stat.do_clear  = r_p_clear;
    assign o_stat.do_scroll = r_p_scroll;
    assign o_stat.copy_last = r_addr == AW'(COPY_LAST);
    assign o_stat.fill_last = r_addr == AW'(CELLS - 1);

    assign o_cell_value    = r_cell_value;
    assign o_cursor_row    = r_cursor_row;
    assign o_cursor_col    = r_cursor_col;
    assign o_cursor_linear = r_cursor_linear;

    `TCE_ASSERT(a_scroll_wr_range, i_clk, i_rst_n, i_cmd.scr_wr |-> (r_addr <= AW'(COPY_LAST)), "scroll copy past last moved cell")
    `TCE_ASSERT(a_scroll_rd_first, i_clk, i_rst_n, i_cmd.scr_wr |-> $past(i_cmd.scr_rd), "scroll write without its read")

endmodule

// ===== sv/tce_ctrl.sv =====
// Controller state machine of the console engine: handshakes, item
// sequencing, sweeps and result valid. Depends on tce_pkg.
`include "assert_macros.svh"

module tce_ctrl import tce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PLAN,
        S_EXEC,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_INIT: begin
                o_cmd.fill_wr   = 1'b1;
                o_cmd.init_mode = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.make_plan = 1'b1;
                n_state         = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                if (i_stat.do_clear) begin
                    n_state = S_FILL;
                end else if (i_stat.do_scroll) begin
                    n_state = S_SCR_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCR_RD: begin
                o_cmd.scr_rd = 1'b1;
                n_state      = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_cmd.scr_wr = 1'b1;
                n_state      = i_stat.copy_last ? S_FILL : S_SCR_RD;
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TCE_ASSERT_ALWAYS(a_reset_blocks_input, i_clk, !i_rst_n |=> !o_in_ready, "input ready during reset sweep")
    `TCE_ASSERT(a_valid_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_DONE), "result valid outside done step")

endmodule

// ===== sv/text_console_engine.sv =====
// Top level of the text console engine: controller, datapath and channels.
// Depends on tce_pkg, tce_if, tce_ctrl and tce_datapath.
//
// Items arrive on i_item (func, char_code, cell_attr, x_pos, y_pos) and each
// yields one result on o_result (cell_value, cursor_row, cursor_col,
// cursor_linear). i_cfg_we with i_cfg_wdata writes the text color.
// One item at a time is in work. A plain item (put char without scroll, set
// cursor, put at, read) goes through plan, execute and done steps after
// acceptance; the done step loads the result register and returns to idle.
// A clear then sweeps every cell to blanks in the text color; a put char that
// scrolls copies rows 1 to ROWS-1 up one row, each cell by a read step and a
// write step on the single RAM port pair, then blanks the last row.
// The result register lets the next item be accepted while a result waits;
// if the receiver stalls, that next item holds in its done step until the
// waiting result is taken.
// After synchronous reset (i_rst_n low) the cell RAM is swept to blanks in
// color 0x0F with i_item.ready low; the color register may be written
// during that sweep.
module text_console_engine import tce_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tce_item_if.sink         i_item,
    tce_result_if.source     o_result,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    tce_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_func          (i_item.func),
        .i_char_code     (i_item.char_code),
        .i_cell_attr     (i_item.cell_attr),
        .i_x_pos         (i_item.x_pos),
        .i_y_pos         (i_item.y_pos),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_cell_value    (o_result.cell_value),
        .o_cursor_row    (o_result.cursor_row),
        .o_cursor_col    (o_result.cursor_col),
        .o_cursor_linear (o_result.cursor_linear)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule
